// ===== sv/tma_pkg.sv =====
package tma_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int H_W      = 3;
    // Weighted sum: |sum| <= 32768 * 64, held in 23 bits signed
    localparam int ACC_W    = 23;
    // Magnitude of the weighted sum
    localparam int MAG_W    = 22;
    // Quotient bits; |sum| / (h+1)^2 <= 32768
    localparam int Q_W      = 16;
    // Tap weight, at most 8
    localparam int W_W      = 4;
    // Divisor (h+1)^2, at most 64
    localparam int DIV_W    = 7;

    // Largest half width the 3-bit register can hold
    localparam logic [H_W-1:0] H_MAXCODE = 3'd7;
    localparam logic [H_W-1:0] HW_RESET  = 3'd2;

    // Register index of half_width
    localparam logic REG_HALF_WIDTH = 1'b0;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       last_res;
    } t_out_item;

    // Control from the sequencer to the tap engine
    typedef struct packed {
        logic shift;
        logic start;
    } t_mac_ctl;

endpackage

// ===== sv/tma_mac.sv =====
module tma_mac #(
    parameter int DEPTH = 15
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tma_pkg::t_mac_ctl                 i_ctl,
    input  logic signed [tma_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [tma_pkg::H_W-1:0]           i_h,
    output logic                              o_done,
    output logic signed [tma_pkg::ACC_W-1:0]  o_acc
);
    import tma_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [SAMPLE_W-1:0] r_dl [DEPTH];
    logic [IW-1:0]              r_j;
    logic                       r_busy;
    logic                       r_done;
    logic signed [ACC_W-1:0]    r_acc;

    logic [7:0]                 j8;
    logic [7:0]                 h8;
    logic [7:0]                 w8;
    logic [W_W-1:0]             w;
    logic signed [SAMPLE_W+W_W:0] prod;
    logic                       last_tap;

    // Delay line, newest sample at tap 0
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_dl[0] <= i_sample;
            for (int i = 1; i < DEPTH; i++) begin
                r_dl[i] <= r_dl[i-1];
            end
        end
    end

    // Triangular weight of the current tap
    always_comb begin
        j8       = 8'(r_j);
        h8       = {{(8-H_W){1'b0}}, i_h};
        w8       = (j8 <= h8) ? (j8 + 8'd1) : ((h8 << 1) - j8 + 8'd1);
        w        = w8[W_W-1:0];
        prod     = r_dl[r_j] * $signed({1'b0, w});
        last_tap = (j8 == (h8 << 1));
    end

    // One tap per cycle into the accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_j    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_j    <= '0;
            end else if (r_busy) begin
                if (last_tap) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_j <= r_j + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + ACC_W'(prod);
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

// ===== sv/tma_div.sv =====
module tma_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [tma_pkg::ACC_W-1:0]    i_acc,
    input  logic [tma_pkg::H_W-1:0]             i_h,
    output logic                                o_done,
    output logic signed [tma_pkg::SAMPLE_W-1:0] o_value
);
    import tma_pkg::*;

    localparam int CNT_W = $clog2(Q_W);

    logic [MAG_W-1:0] r_mag;
    logic [MAG_W-1:0] r_ds;
    logic [Q_W-1:0]   r_q;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [3:0]       hp1;
    logic [7:0]       dv;
    logic [ACC_W-1:0] abs_acc;
    logic             ge;

    // Divisor (h+1)^2 and dividend magnitude
    always_comb begin
        hp1     = {1'b0, i_h} + 4'd1;
        dv      = {4'd0, hp1} * {4'd0, hp1};
        abs_acc = i_acc[ACC_W-1] ? ACC_W'(-i_acc) : ACC_W'(i_acc);
        ge      = (r_mag >= r_ds);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
        end
    end

    // Restoring division, one quotient bit per cycle, MSB first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= abs_acc[MAG_W-1:0];
            r_ds  <= {dv[DIV_W-1:0], {(Q_W-1){1'b0}}};
            r_neg <= i_acc[ACC_W-1];
            r_q   <= '0;
        end else if (r_busy) begin
            r_mag <= ge ? (r_mag - r_ds) : r_mag;
            r_ds  <= r_ds >> 1;
            r_q   <= {r_q[Q_W-2:0], ge};
        end
    end

    // Sign back on; truncation toward zero
    assign o_done  = r_done;
    assign o_value = $signed(r_neg ? SAMPLE_W'(-r_q) : SAMPLE_W'(r_q));

endmodule

// ===== sv/triangular_moving_average_unit.sv =====
// Channel  Signals                                  Direction  Carries
// input    i_in_valid / o_in_ready / i_in_item      in         sample, last
// output   o_out_valid / i_out_ready / o_out_item   out        value, last_res
// config   psel penable pwrite paddr pwdata prdata  in/out     half_width at 0x0
//
// A smoothed result passes through the tap accumulator, then the bit-serial
// divider, then the output register; a zero result skips both engines.
// A last item is followed by its trailing zero results.
// One item is in work at a time; the next is taken once the final result of
// the current one sits in the output register.
// Synchronous active-low reset clears control state and sets h to 2.
module triangular_moving_average_unit #(
    parameter int MAX_HALF = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tma_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tma_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tma_pkg::*;

    localparam int DEPTH = 2 * MAX_HALF + 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int RW    = $clog2(MAX_HALF + 2);
    localparam logic [H_W-1:0] HCAP = (MAX_HALF > 7) ? H_MAXCODE : H_W'(MAX_HALF);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MAC  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]          r_state;
    logic [H_W-1:0]      r_hw;
    logic [CW-1:0]       r_cnt;
    logic [RW-1:0]       r_rem;
    logic                r_last;
    logic [H_W-1:0]      r_h;
    logic signed [SAMPLE_W-1:0] r_val;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [H_W-1:0]      h_eff;
    logic [7:0]          n8;
    logic [7:0]          h8;
    logic                has_first;
    logic                do_smooth;
    logic [7:0]          total8;
    logic                in_acc;
    logic                out_free;
    logic                emit_load;
    logic                cfg_wr;

    t_mac_ctl            mac_ctl;
    logic                mac_done;
    logic signed [ACC_W-1:0] mac_acc;
    logic                div_start;
    logic                div_done;
    logic signed [SAMPLE_W-1:0] div_value;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = 32'(r_hw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw <= HW_RESET;
        end else if (cfg_wr && (paddr[2] == REG_HALF_WIDTH)) begin
            r_hw <= pwdata[H_W-1:0];
        end
    end

    // Result count for an accepted item
    always_comb begin
        h_eff     = (r_hw > HCAP) ? HCAP : r_hw;
        n8        = 8'(r_cnt);
        h8        = {{(8-H_W){1'b0}}, h_eff};
        has_first = (n8 >= h8);
        do_smooth = (n8 >= (h8 << 1));
        if (i_in_item.last) begin
            total8 = has_first ? (h8 + 8'd1) : (n8 + 8'd1);
        end else begin
            total8 = has_first ? 8'd1 : 8'd0;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign emit_load  = (r_state == S_EMIT) && out_free;
    assign div_start  = (r_state == S_MAC) && mac_done;

    assign mac_ctl.shift = in_acc;
    assign mac_ctl.start = in_acc && do_smooth;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_rem   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_rem <= RW'(total8);
                        if (i_in_item.last) begin
                            r_cnt <= '0;
                        end else if (n8 < 8'(DEPTH)) begin
                            r_cnt <= CW'(n8 + 8'd1);
                        end
                        if (total8 == 8'd0) begin
                            r_state <= S_IDLE;
                        end else if (do_smooth) begin
                            r_state <= S_MAC;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_MAC: begin
                    if (mac_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_rem <= r_rem - RW'(1);
                        if (r_rem == RW'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Item payload held while in work
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_last <= i_in_item.last;
            r_h    <= h_eff;
            r_val  <= '0;
        end else if ((r_state == S_DIV) && div_done) begin
            r_val <= div_value;
        end else if (emit_load) begin
            r_val <= '0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_out.value    <= r_val;
            r_out.last_res <= r_last && (r_rem == RW'(1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    tma_mac #(
        .DEPTH (DEPTH)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_sample (i_in_item.sample),
        .i_h      (h_eff),
        .o_done   (mac_done),
        .o_acc    (mac_acc)
    );

    tma_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_acc   (mac_acc),
        .i_h     (r_h),
        .o_done  (div_done),
        .o_value (div_value)
    );

endmodule

// ===== sv/tma_checker.sv =====
module tma_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input tma_pkg::t_out_item o_out_item,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [2:0]         paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               pready
);
    import tma_pkg::*;

    // Reset leaves no result pending and the input open
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output item changed while stalled");

    // An idle block with no new item produces no result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && !i_in_valid && !o_out_valid |=> !o_out_valid)
        else $error("result without an item");

    // A half_width write reads back
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && (paddr[2] == REG_HALF_WIDTH)
        |=> prdata[H_W-1:0] == $past(pwdata[H_W-1:0]))
        else $error("half_width readback mismatch");

endmodule

bind triangular_moving_average_unit tma_checker u_tma_checker (.*);

// ===== sim/triangular_moving_average_unit_tb.sv =====
`timescale 1ns / 1ps

module triangular_moving_average_unit_tb;
    import tma_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int MAX_HALF     = 7;
    localparam int TAP_DEPTH    = 2 * MAX_HALF + 1;
    localparam int RANDOM_ITEMS = 105;
    // Margin over the longest smoothed result
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_CYCLES  = 60;
    localparam int STALL_LIMIT   = 1000;

    localparam logic [2:0] ADDR_HALF_WIDTH = {REG_HALF_WIDTH, 2'b00};
    // Index 1: no register there, writes must be dropped
    localparam logic [2:0] ADDR_UNMAPPED   = 3'd4;

    typedef enum logic [0:0] {
        ROW_CFG_WRITE,
        ROW_SAMPLE
    } t_row_kind;

    typedef struct packed {
        t_row_kind                  kind;
        logic [2:0]                 addr;
        logic [31:0]                wdata;
        t_in_item                   item;
        logic                       typed;
        logic signed [SAMPLE_W-1:0] typed_value;
    } t_stim_row;

    localparam int N_DIRECTED = 26;

    // Directed stimulus; typed_value is the first result of the row where typed is set
    t_stim_row directed_rows [N_DIRECTED] = '{
        // h = 2 after reset: full-scale positive run, edges are zero
        '{ROW_SAMPLE, 3'd0, 32'd0, '{16'sh7FFF, 1'b0}, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 3'd0, 32'd0, '{16'sh7FFF, 1'b0}, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 3'd0, 32'd0, '{16'sh7FFF, 1'b0}, 1'b1, 16'sh0000},
        '{ROW_SAMPLE, 3'd0, 32'd0, '{16'sh7FFF, 1'b0}, 1'b1, 16'sh0000},
        '{ROW_SAMPLE, 3'd0, 32'd0, '{16'sh7FFF, 1'b1}, 1'b1, 16'sh7FFF},
        // full-scale negative run
        '{ROW_SAMPLE, 3'd0, 32'd0, '{16'sh8000, 1'b0}, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 3'd0, 32'd0, '{16'sh8000, 1'b0}, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 3'd0, 32'd0, '{16'sh8000, 1'b0}, 1'b1, 16'sh0000},
        '{ROW_SAMPLE, 3'd0, 32'd0, '{16'sh8000, 1'b0}, 1'b1, 16'sh0000},
        '{ROW_SAMPLE, 3'd0, 32'd0, '{16'sh8000, 1'b1}, 1'b1, 16'sh8000},
        // h = 0: pass-through, alternating bit patterns
        '{ROW_CFG_WRITE, ADDR_HALF_WIDTH, 32'h0000_0000, '{16'sh0000, 1'b0}, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 3'd0, 32'd0, '{16'sh8000, 1'b0}, 1'b1, 16'sh8000},
        '{ROW_SAMPLE, 3'd0, 32'd0, '{16'sh7FFF, 1'b0}, 1'b1, 16'sh7FFF},
        '{ROW_SAMPLE, 3'd0, 32'd0, '{16'sh5555, 1'b0}, 1'b1, 16'sh5555},
        '{ROW_SAMPLE, 3'd0, 32'd0, '{16'shAAAA, 1'b1}, 1'b1, 16'shAAAA},
        // write to an unmapped index leaves h at 0
        '{ROW_CFG_WRITE, ADDR_UNMAPPED, 32'h0000_0007, '{16'sh0000, 1'b0}, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 3'd0, 32'd0, '{16'sh04D2, 1'b1}, 1'b1, 16'sh04D2},
        // h = 7 (upper data bits ignored): short sequences give only zeros
        '{ROW_CFG_WRITE, ADDR_HALF_WIDTH, 32'hFFFF_FFFF, '{16'sh0000, 1'b0}, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 3'd0, 32'd0, '{16'sh0001, 1'b0}, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 3'd0, 32'd0, '{16'shFFFF, 1'b0}, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 3'd0, 32'd0, '{16'sh1234, 1'b1}, 1'b1, 16'sh0000},
        '{ROW_SAMPLE, 3'd0, 32'd0, '{16'sh7FFF, 1'b1}, 1'b1, 16'sh0000},
        // h = 1: one smoothed value, (256 + 2*512 + 768) / 4 = 512
        '{ROW_CFG_WRITE, ADDR_HALF_WIDTH, 32'hFFFF_FFF9, '{16'sh0000, 1'b0}, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 3'd0, 32'd0, '{16'sh0100, 1'b0}, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 3'd0, 32'd0, '{16'sh0200, 1'b0}, 1'b1, 16'sh0000},
        '{ROW_SAMPLE, 3'd0, 32'd0, '{16'sh0300, 1'b1}, 1'b1, 16'sh0200}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Directed expectation that travels with the item on the input channel
    logic                       item_typed = 1'b0;
    logic signed [SAMPLE_W-1:0] item_typed_value = '0;

    // Shadow state of the smoother
    logic [H_W-1:0]             half_width_reg = HW_RESET;
    logic signed [SAMPLE_W-1:0] taps [TAP_DEPTH] = '{default: '0};
    int unsigned                seq_count = 0;
    t_out_item                  expected_q [$];

    int mismatches = 0;
    int idle_cycles = 0;

    triangular_moving_average_unit #(
        .MAX_HALF(MAX_HALF)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Weighted window sum over the newest 2h+1 taps, divided by (h+1)^2
    function automatic logic signed [SAMPLE_W-1:0] tri_average(int unsigned h);
        longint acc;
        longint wsum;
        int unsigned w;
        acc = 0;
        wsum = longint'((h + 1) * (h + 1));
        for (int unsigned j = 0; j <= 2 * h; j++) begin
            w = ((j < 2 * h - j) ? j : 2 * h - j) + 1;
            acc += longint'(taps[j]) * longint'(w);
        end
        return SAMPLE_W'(acc / wsum);
    endfunction

    // Shift the sample in and queue the results it releases
    task automatic predict_item(t_in_item it, logic typed, logic signed [SAMPLE_W-1:0] typed_v);
        int unsigned h;
        int unsigned n;
        int unsigned total;
        t_out_item   res;
        h = (half_width_reg > MAX_HALF) ? MAX_HALF : half_width_reg;
        n = seq_count;
        for (int j = TAP_DEPTH - 1; j > 0; j--) begin
            taps[j] = taps[j-1];
        end
        taps[0] = it.sample;
        if (!it.last) begin
            total = (n >= h) ? 1 : 0;
        end else begin
            total = (n >= h) ? h + 1 : n + 1;
        end
        for (int unsigned i = 0; i < total; i++) begin
            res.value = (i == 0 && n >= 2 * h) ? tri_average(h) : '0;
            if (i == 0 && typed) begin
                res.value = typed_v;
            end
            res.last_res = it.last && (i == total - 1);
            expected_q.push_back(res);
        end
        if (it.last) begin
            seq_count = 0;
        end else if (n < TAP_DEPTH) begin
            seq_count = n + 1;
        end
    endtask

    // Register shadow
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            half_width_reg <= HW_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_HALF_WIDTH) begin
            half_width_reg <= pwdata[H_W-1:0];
        end
    end

    // Input acceptance feeds the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && in_ready) begin
            predict_item(in_item, item_typed, item_typed_value);
        end
    end

    // Result check against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t ns: unexpected item, expected none, got value %0d last_res %0b",
                         $time, out_item.value, out_item.last_res);
                mismatches++;
            end else begin
                exp_item = expected_q.pop_front();
                if (out_item.value !== exp_item.value) begin
                    $display("%0t ns: value expected %0d, got %0d",
                             $time, exp_item.value, out_item.value);
                    mismatches++;
                end
                if (out_item.last_res !== exp_item.last_res) begin
                    $display("%0t ns: last_res expected %0b, got %0b",
                             $time, exp_item.last_res, out_item.last_res);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t ns: timeout, %0d results outstanding", $time, expected_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Output side: random stalls per item, with occasional no-stall stretches
    initial begin : result_sink
        int unsigned stall;
        bit          rx_burst;
        rx_burst = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if ($urandom_range(0, 15) == 0) begin
                rx_burst = !rx_burst;
            end
            stall = rx_burst ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!out_valid);
        end
    end

    task automatic send_item(t_in_item it, logic typed, logic signed [SAMPLE_W-1:0] typed_v,
                             bit no_gap);
        int unsigned gap;
        gap = no_gap ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid         <= 1'b1;
        in_item          <= it;
        item_typed       <= typed;
        item_typed_value <= typed_v;
        do @(posedge i_clk); while (!in_ready);
    endtask

    // Block drained and quiet before a register write
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write, then read back half_width
    task automatic write_register(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_HALF_WIDTH;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(half_width_reg)) begin
            $display("%0t ns: half_width read expected %0d, got %0d",
                     $time, half_width_reg, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        unique case ($urandom_range(0, 5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return SAMPLE_W'($signed($urandom_range(0, 31)) - 16);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    function automatic logic [H_W-1:0] random_half_width();
        unique case ($urandom_range(0, 3))
            0:       return '0;
            1:       return H_MAXCODE;
            default: return H_W'($urandom_range(0, 7));
        endcase
    endfunction

    // Main stimulus
    initial begin : stimulus
        int          sent;
        int unsigned seq_len;
        bit          tx_burst;
        t_in_item    it;
        sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (directed_rows[r].kind == ROW_CFG_WRITE) begin
                wait_idle();
                write_register(directed_rows[r].addr, directed_rows[r].wdata);
            end else begin
                send_item(directed_rows[r].item, directed_rows[r].typed,
                          directed_rows[r].typed_value, 1'b0);
            end
        end

        // Random sequences, each closed by a last sample
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 1) == 0) begin
                wait_idle();
                if ($urandom_range(0, 5) == 0) begin
                    write_register(ADDR_UNMAPPED, $urandom());
                end
                write_register(ADDR_HALF_WIDTH,
                               ($urandom() & ~32'h7) | 32'(random_half_width()));
            end
            seq_len = ($urandom_range(0, 6) == 0) ? $urandom_range(16, 22)
                                                 : $urandom_range(1, 12);
            tx_burst = ($urandom_range(0, 3) == 0);
            for (int unsigned k = 0; k < seq_len; k++) begin
                // Occasional width change in the middle of a sequence
                if (k > 0 && $urandom_range(0, 19) == 0) begin
                    wait_idle();
                    write_register(ADDR_HALF_WIDTH, 32'(random_half_width()));
                end
                it.sample = random_sample();
                it.last   = (k == seq_len - 1);
                send_item(it, 1'b0, '0, tx_burst);
                sent++;
            end
        end

        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/tma_pkg.sv
sv/tma_mac.sv
sv/tma_div.sv
sv/triangular_moving_average_unit.sv
sv/tma_checker.sv
sim/triangular_moving_average_unit_tb.sv
